>>> sv/assert_macros.svh
// Assertion macros shared by the receiver modules.
// Include this header before writing any concurrent checks; it needs no other file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

>>> sv/srr_pkg.sv
// Types and constants of the selective repeat receiver.
// No dependencies; every other source file but assert_macros.svh imports this package.
package srr_pkg;

  localparam int MAX_PACKETS = 16384;
  localparam int MAP_AW      = $clog2(MAX_PACKETS);
  localparam int TOTAL_W     = $clog2(MAX_PACKETS + 1);
  localparam int BASE_W      = 14;
  localparam int CSUM_WORDS  = 8;
  localparam int CSUM_CNT_W  = $clog2(CSUM_WORDS);

  localparam int FLAG_FIN   = 1;
  localparam int FLAG_START = 2;
  localparam int FLAG_EXT   = 5;

  localparam logic [15:0] CLOSE_SEQ = 16'd65534;
  localparam logic [15:0] CLOSE_ACK = 16'd65535;

  localparam logic [2:0] KIND_START = 3'd0;
  localparam logic [2:0] KIND_NEW   = 3'd1;
  localparam logic [2:0] KIND_DUP   = 3'd2;
  localparam logic [2:0] KIND_FIN   = 3'd3;
  localparam logic [2:0] KIND_CLOSE = 3'd4;

  typedef struct packed {
    logic [31:0] flags;
    logic [15:0] sequence_req;
    logic [15:0] ack_number_in;
    logic [31:0] length;
    logic [31:0] packet_count;
    logic [15:0] checksum;
  } in_word_t;

  typedef struct packed {
    logic [15:0]       ack_number;
    logic [2:0]        ack_kind;
    logic [BASE_W-1:0] window_base;
    logic              transfer_done;
    logic [31:0]       last_length;
  } out_word_t;

  typedef struct packed {
    logic valid;
    logic ok;
  } csum_status_t;

endpackage

>>> sv/srr_channels.sv
// Valid/ready channels of the receiver: header words in, ack words out.
// Depends on srr_pkg for the payload types.
interface srr_in_if import srr_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface srr_out_if import srr_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> sv/srr_csum.sv
// Iterative header checksum: one byte-swapped 16-bit word folded per cycle.
// Depends on srr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module srr_csum import srr_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  in_word_t     hdr,
  output csum_status_t status
);

  logic [15:0]           words [CSUM_WORDS];
  logic [CSUM_CNT_W-1:0] cnt;
  logic                  busy;
  logic                  res_valid;
  logic [15:0]           sum;
  logic [15:0]           peer_csum;
  logic [16:0]           sum_wide;
  logic [15:0]           chk;

  function automatic logic [15:0] swap16(input logic [15:0] v);
    return {v[7:0], v[15:8]};
  endfunction

  assign sum_wide = {1'b0, sum} + {1'b0, words[0]};
  assign chk      = sum + peer_csum;
  assign status.valid = res_valid;
  assign status.ok    = (chk == 16'hFFFF);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      res_valid <= 1'b0;
      cnt       <= '0;
    end else if (start) begin
      busy      <= 1'b1;
      res_valid <= 1'b0;
      cnt       <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CSUM_CNT_W'(CSUM_WORDS - 1)) begin
        busy      <= 1'b0;
        res_valid <= 1'b1;
      end
    end
  end

  // Each field is little-endian on the wire and pairs are read high byte first.
  always_ff @(posedge clk) begin
    if (start) begin
      words[0]  <= swap16(hdr.flags[15:0]);
      words[1]  <= swap16(hdr.flags[31:16]);
      words[2]  <= swap16(hdr.sequence_req);
      words[3]  <= swap16(hdr.ack_number_in);
      words[4]  <= swap16(hdr.length[15:0]);
      words[5]  <= swap16(hdr.length[31:16]);
      words[6]  <= swap16(hdr.packet_count[15:0]);
      words[7]  <= swap16(hdr.packet_count[31:16]);
      sum       <= '0;
      peer_csum <= hdr.checksum;
    end else if (busy) begin
      // One fold is enough: the carry added back can never carry again.
      sum <= sum_wide[15:0] + {15'b0, sum_wide[16]};
      for (int i = 0; i < CSUM_WORDS - 1; i++) begin
        words[i] <= words[i+1];
      end
    end
  end

  `ASSERT_NEXT(a_sum_finishes, clk, rst, busy && !start && cnt == CSUM_CNT_W'(CSUM_WORDS - 1), status.valid, "checksum did not finish after the last word")
  `ASSERT_ALWAYS(a_busy_excl, clk, rst, !(busy && res_valid), "checksum busy while result shown")
  `ASSERT_IMPLIES(a_cnt_idle, clk, rst, !busy, cnt == '0, "word counter not cleared while idle")

endmodule

>>> sv/srr_map_ram.sv
// Received map: one bit per sequence, one write and one registered read a cycle.
// Depends on srr_pkg for the address width.
module srr_map_ram import srr_pkg::*; (
  input  logic              clk,
  input  logic              we,
  input  logic [MAP_AW-1:0] waddr,
  input  logic              wdata,
  input  logic [MAP_AW-1:0] raddr,
  output logic              rdata
);

  logic mem [MAX_PACKETS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/selective_repeat_receiver.sv
// Selective repeat receiver, header path. A header word is taken only in the idle
// state, so the next one waits until the last is through: it is accepted, checked
// in the checksum unit (one 16-bit word folded per cycle), the checksum result is
// picked up and the header is decided, with the received map read during the
// checksum. A new data word then walks the map from the window base, a memory read
// and a check for every entry (including the entry that ends the walk), and then
// posts the ack. After reset, and after every START ack, the block sweeps all 16384
// map entries, one entry a cycle, and takes no header during the sweep. One finished
// ack waits in the output register while the next header is processed.
`include "assert_macros.svh"

module selective_repeat_receiver import srr_pkg::*; (
  input logic      clk,
  input logic      rst,
  srr_in_if.sink   header,
  srr_out_if.source result
);

  localparam logic [2:0] S_CLEAR    = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_SUM      = 3'd2;
  localparam logic [2:0] S_DECIDE   = 3'd3;
  localparam logic [2:0] S_WALK_RD  = 3'd4;
  localparam logic [2:0] S_WALK_CHK = 3'd5;
  localparam logic [2:0] S_EMIT     = 3'd6;

  logic [2:0]         state;
  logic [MAP_AW-1:0]  clear_addr;
  logic               receiving;
  logic               closed;
  logic [TOTAL_W-1:0] total;
  logic [MAP_AW-1:0]  base;
  logic [31:0]        final_length;
  logic               walk_done;
  in_word_t           hdr;

  logic               out_valid;
  out_word_t          out_data;
  logic               out_free;
  logic               out_load;
  out_word_t          out_next;

  csum_status_t       cs_st;
  logic               accept;

  logic               map_we;
  logic [MAP_AW-1:0]  map_waddr;
  logic               map_wdata;
  logic [MAP_AW-1:0]  map_raddr;
  logic               map_rdata;

  logic               hdr_good;
  logic [TOTAL_W-1:0] total_m1;
  logic               in_range;
  logic               is_dup;
  logic               dec_emit;
  logic               dec_mark;
  logic               dec_start;
  logic               dec_close;

  assign header.ready = (state == S_IDLE);
  assign accept       = header.valid && header.ready;
  assign result.valid = out_valid;
  assign result.data  = out_data;
  assign out_free     = !out_valid || result.ready;

  srr_csum u_csum (
    .clk    (clk),
    .rst    (rst),
    .start  (accept),
    .hdr    (header.data),
    .status (cs_st)
  );

  srr_map_ram u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  assign hdr_good = !closed && hdr.flags[FLAG_EXT] && cs_st.ok;
  assign total_m1 = total - 1'b1;
  assign in_range = hdr.sequence_req < 16'(total);
  assign is_dup   = map_rdata || (hdr.sequence_req < 16'(base));

  // The map is read at the header's sequence while the checksum runs, so the bit
  // is ready in the decide cycle; the walk reads at the window base.
  assign map_raddr = (state == S_WALK_RD) ? base : hdr.sequence_req[MAP_AW-1:0];
  assign map_we    = (state == S_CLEAR) || dec_mark;
  assign map_waddr = (state == S_CLEAR) ? clear_addr : hdr.sequence_req[MAP_AW-1:0];
  assign map_wdata = (state != S_CLEAR);

  always_comb begin
    dec_emit  = 1'b0;
    dec_mark  = 1'b0;
    dec_start = 1'b0;
    dec_close = 1'b0;
    out_next  = '{ack_number: hdr.sequence_req, ack_kind: KIND_DUP,
                  window_base: BASE_W'(base), transfer_done: 1'b0,
                  last_length: final_length};
    if (state == S_DECIDE && hdr_good) begin
      if (!receiving) begin
        if (hdr.flags[FLAG_FIN]) begin
          dec_emit            = 1'b1;
          out_next.ack_number = hdr.sequence_req + 16'd1;
          out_next.ack_kind   = KIND_FIN;
        end else if (hdr.flags[FLAG_START]) begin
          dec_emit             = 1'b1;
          dec_start            = 1'b1;
          out_next.ack_kind    = KIND_START;
          out_next.window_base = '0;
          out_next.last_length = '0;
        end
      end else if (hdr.sequence_req == CLOSE_SEQ) begin
        dec_emit            = 1'b1;
        dec_close           = 1'b1;
        out_next.ack_number = CLOSE_ACK;
        out_next.ack_kind   = KIND_CLOSE;
      end else if (in_range) begin
        if (is_dup) begin
          dec_emit = 1'b1;
        end else begin
          dec_mark = 1'b1;
        end
      end
    end
    if (state == S_EMIT) begin
      out_next.ack_kind      = KIND_NEW;
      out_next.transfer_done = walk_done;
    end
    out_load = out_free && (dec_emit || state == S_EMIT);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hdr <= header.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= out_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clear_addr   <= '0;
      receiving    <= 1'b0;
      closed       <= 1'b0;
      total        <= '0;
      base         <= '0;
      final_length <= '0;
      walk_done    <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          clear_addr <= clear_addr + 1'b1;
          if (clear_addr == MAP_AW'(MAX_PACKETS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state <= S_SUM;
          end
        end
        S_SUM: begin
          if (cs_st.valid) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (dec_emit && !out_free) begin
            state <= S_DECIDE;
          end else if (dec_mark) begin
            if (hdr.sequence_req == 16'(total_m1)) begin
              final_length <= hdr.length;
            end
            walk_done <= 1'b0;
            state     <= S_WALK_RD;
          end else if (dec_start) begin
            total <= (hdr.packet_count > 32'(MAX_PACKETS)) ?
                     TOTAL_W'(MAX_PACKETS) : hdr.packet_count[TOTAL_W-1:0];
            base         <= '0;
            final_length <= '0;
            receiving    <= 1'b1;
            clear_addr   <= '0;
            state        <= S_CLEAR;
          end else begin
            if (dec_close) begin
              closed    <= 1'b1;
              receiving <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        S_WALK_RD: begin
          state <= S_WALK_CHK;
        end
        S_WALK_CHK: begin
          if (map_rdata) begin
            if (TOTAL_W'(base) == total_m1) begin
              // Last packet in: the base stays on the last sequence.
              walk_done <= 1'b1;
              receiving <= 1'b0;
              state     <= S_EMIT;
            end else begin
              base  <= base + 1'b1;
              state <= S_WALK_RD;
            end
          end else begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_IMPLIES(a_base_in_window, clk, rst, receiving && total != '0, TOTAL_W'(base) < total, "window base beyond packet total")
  `ASSERT_IMPLIES(a_closed_idle, clk, rst, closed, !receiving, "receiving after close")
  `ASSERT_IMPLIES(a_no_accept_clear, clk, rst, state == S_CLEAR, !header.ready, "header taken during map sweep")

endmodule
